FILE: hdl/bst_pkg.sv
// bst_pkg: shared types and constants for the bounding sphere transform
// fixed point widths, payload structs and register indexes
// no dependencies
package bst_pkg;

  localparam int QFrac     = 16;
  localparam int DataW     = 32;
  localparam int RadW      = 31;
  localparam int ProdW     = 64;
  localparam int SumW      = ProdW + 2;
  localparam int HiW       = SumW - QFrac + 1;
  localparam int SqW       = 64;
  localparam int LenW      = 33;
  localparam int RootSteps = 32;
  localparam int RoundHalf = 1 << (QFrac - 1);
  localparam int AddrW     = 4;
  localparam int ApbW      = 32;

  localparam logic [1:0] RegOffX = 2'd0;
  localparam logic [1:0] RegOffY = 2'd1;
  localparam logic [1:0] RegOffZ = 2'd2;
  localparam logic [1:0] RegRad  = 2'd3;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic [RadW-1:0]         rad_t;

  localparam q_t   QMax        = 32'sh7fffffff;
  localparam q_t   QMin        = 32'sh80000000;
  localparam rad_t RadMax      = '1;
  localparam rad_t RadiusReset = 31'd32768;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec_t;

  typedef struct packed {
    vec_t col0;
    vec_t col1;
    vec_t col2;
    vec_t trans;
  } matrix_t;

  typedef struct packed {
    vec_t           center;
    logic [SqW-1:0] smax;
  } front_t;

  typedef struct packed {
    vec_t           center;
    logic [SqW-1:0] rem;
    logic [SqW-1:0] root;
  } root_t;

  typedef struct packed {
    vec_t center;
    rad_t radius;
  } sphere_t;

endpackage

FILE: hdl/bst_if.sv
// bst_if: valid/ready channel interfaces for matrix input and sphere output
// depends on bst_pkg
interface bst_matrix_if;
  import bst_pkg::*;
  logic valid;
  logic ready;
  q_t   col0_x;
  q_t   col0_y;
  q_t   col0_z;
  q_t   col1_x;
  q_t   col1_y;
  q_t   col1_z;
  q_t   col2_x;
  q_t   col2_y;
  q_t   col2_z;
  q_t   trans_x;
  q_t   trans_y;
  q_t   trans_z;

  modport source (
    output valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    input  ready
  );
  modport sink (
    input  valid, col0_x, col0_y, col0_z, col1_x, col1_y, col1_z,
           col2_x, col2_y, col2_z, trans_x, trans_y, trans_z,
    output ready
  );
endinterface

interface bst_sphere_if;
  import bst_pkg::*;
  logic valid;
  logic ready;
  q_t   center_x;
  q_t   center_y;
  q_t   center_z;
  rad_t world_radius;

  modport source (
    output valid, center_x, center_y, center_z, world_radius,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, world_radius,
    output ready
  );
endinterface

FILE: hdl/bst_front.sv
// bst_front: three stage front end, products, sums, rounding and saturation
// produces the world center and the largest squared column length
// depends on bst_pkg
module bst_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bst_pkg::matrix_t in_data,
  input  bst_pkg::vec_t    offset,
  output logic             out_valid,
  input  logic             out_ready,
  output bst_pkg::front_t  out_data
);
  import bst_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  q_t col [3][3];
  q_t off [3];
  q_t tr  [3];

  logic signed [ProdW-1:0] cprod [3][3];
  logic [SqW-1:0]          sq    [3][3];
  vec_t                    trans_a;

  logic signed [SumW-1:0]  csum  [3];
  logic [SqW-1:0]          slen  [3];
  vec_t                    trans_b;

  q_t                      ctr_next [3];
  logic [SqW-1:0]          smax_next;
  vec_t                    center;
  logic [SqW-1:0]          smax;

  assign col[0][0] = in_data.col0.x;
  assign col[0][1] = in_data.col0.y;
  assign col[0][2] = in_data.col0.z;
  assign col[1][0] = in_data.col1.x;
  assign col[1][1] = in_data.col1.y;
  assign col[1][2] = in_data.col1.z;
  assign col[2][0] = in_data.col2.x;
  assign col[2][1] = in_data.col2.y;
  assign col[2][2] = in_data.col2.z;
  assign off[0]    = offset.x;
  assign off[1]    = offset.y;
  assign off[2]    = offset.z;
  assign tr[0]     = trans_b.x;
  assign tr[1]     = trans_b.y;
  assign tr[2]     = trans_b.z;

  assign adv[2]   = ~v[2] | out_ready;
  assign adv[1]   = ~v[1] | adv[2];
  assign adv[0]   = ~v[0] | adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  // stage a: products
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int a = 0; a < 3; a++) begin
        for (int j = 0; j < 3; j++) begin
          cprod[a][j] <= col[j][a] * off[j];
          sq[j][a]    <= col[j][a] * col[j][a];
        end
      end
      trans_a <= in_data.trans;
    end
  end

  // stage b: exact sums, with the rounding half added to the center sums
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int a = 0; a < 3; a++) begin
        csum[a] <= SumW'(cprod[a][0]) + SumW'(cprod[a][1]) + SumW'(cprod[a][2])
                   + SumW'(RoundHalf);
        slen[a] <= sq[a][0] + sq[a][1] + sq[a][2];
      end
      trans_b <= trans_a;
    end
  end

  // stage c: rounding, translation, saturation, largest length
  always_comb begin
    logic signed [HiW-1:0] hsum;
    for (int a = 0; a < 3; a++) begin
      hsum = HiW'(csum[a] >>> QFrac) + HiW'(tr[a]);
      if ((&hsum[HiW-1:DataW-1]) || !(|hsum[HiW-1:DataW-1])) begin
        ctr_next[a] = hsum[DataW-1:0];
      end else if (hsum[HiW-1]) begin
        ctr_next[a] = QMin;
      end else begin
        ctr_next[a] = QMax;
      end
    end
    smax_next = slen[0];
    if (slen[1] > smax_next) smax_next = slen[1];
    if (slen[2] > smax_next) smax_next = slen[2];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      center <= '{x: ctr_next[0], y: ctr_next[1], z: ctr_next[2]};
      smax   <= smax_next;
    end
  end

  assign out_valid = v[2];
  assign out_data  = '{center: center, smax: smax};

endmodule

FILE: hdl/bst_sqrt.sv
// bst_sqrt: pipelined digit-by-digit square root of the largest squared length
// StepsPerStage result bits per stage, the center rides along
// depends on bst_pkg
module bst_sqrt #(
  parameter int StepsPerStage = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bst_pkg::front_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bst_pkg::root_t  out_data
);
  import bst_pkg::*;

  localparam int Stages = RootSteps / StepsPerStage;

  logic  v   [Stages];
  logic  adv [Stages];
  root_t d   [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    root_t src;
    root_t nxt;
    logic  src_v;
    logic  dn_ready;

    if (k == 0) begin : g_first
      assign src   = '{center: in_data.center, rem: in_data.smax, root: '0};
      assign src_v = in_valid;
    end else begin : g_mid
      assign src   = d[k-1];
      assign src_v = v[k-1];
    end

    if (k == Stages - 1) begin : g_last
      assign dn_ready = out_ready;
    end else begin : g_inner
      assign dn_ready = adv[k+1];
    end

    assign adv[k] = ~v[k] | dn_ready;

    always_comb begin
      logic [SqW-1:0] rem;
      logic [SqW-1:0] rt;
      logic [SqW-1:0] bval;
      logic [SqW-1:0] trial;
      rem = src.rem;
      rt  = src.root;
      for (int i = 0; i < StepsPerStage; i++) begin
        bval  = SqW'(1) << (SqW - 2 - 2 * (k * StepsPerStage + i));
        trial = rt + bval;
        if (rem >= trial) begin
          rem = rem - trial;
          rt  = (rt >> 1) + bval;
        end else begin
          rt  = rt >> 1;
        end
      end
      nxt = '{center: src.center, rem: rem, root: rt};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        d[k] <= nxt;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[Stages-1];
  assign out_data  = d[Stages-1];

endmodule

FILE: hdl/bst_scale.sv
// bst_scale: root rounding, radius multiply, final rounding and saturation
// last stage is the output register
// depends on bst_pkg
module bst_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bst_pkg::root_t   in_data,
  input  bst_pkg::rad_t    radius,
  output logic             out_valid,
  input  logic             out_ready,
  output bst_pkg::sphere_t out_data
);
  import bst_pkg::*;

  logic [2:0] v;
  logic [2:0] adv;

  logic [LenW-1:0]  len1;
  vec_t             ctr1;
  logic [ProdW-1:0] prod2;
  vec_t             ctr2;
  logic [ProdW-1:0] rnd;
  sphere_t          res;

  assign adv[2]   = ~v[2] | out_ready;
  assign adv[1]   = ~v[1] | adv[2];
  assign adv[0]   = ~v[0] | adv[1];
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      if (adv[1]) v[1] <= v[0];
      if (adv[2]) v[2] <= v[1];
    end
  end

  // round root to nearest, half up
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      len1 <= in_data.root[LenW-1:0] + LenW'(in_data.rem > in_data.root);
      ctr1 <= in_data.center;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      prod2 <= radius * len1;
      ctr2  <= ctr1;
    end
  end

  assign rnd = (prod2 + ProdW'(RoundHalf)) >> QFrac;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      res.center <= ctr2;
      res.radius <= (|rnd[ProdW-1:RadW]) ? RadMax : rnd[RadW-1:0];
    end
  end

  assign out_valid = v[2];
  assign out_data  = res;

endmodule

FILE: hdl/bounding_sphere_transform_top.sv
// bounding_sphere_transform_top: world bounding sphere from an affine matrix
// apb register block, front end, square root pipeline and radius scaling
// depends on bst_pkg, bst_if, bst_front, bst_sqrt, bst_scale
//
// usage:
//   matrix channel takes one beat per matrix: three basis columns and a
//   translation, all signed q16.16. sphere channel returns one beat per
//   matrix: saturated world center and world radius, in input order.
//   offsets and local radius are written over the apb port while idle;
//   byte address 4*i, i = offset_x, offset_y, offset_z, local_radius.
//   throughput is one beat per cycle while the sphere channel is not stalled.
//   the root pipeline resolves RootStepsPerStage bits of the root per stage.
//   every stage holds its own valid bit and only waits when the stage
//   after it is full, so bubbles close up and matrix.ready stays high
//   while the pipeline has room, even with a result waiting on the output.
//   a stalled sphere beat holds its value until taken.
//   reset empties the pipeline, offsets go to zero, local radius to 0.5.
module bounding_sphere_transform_top #(
  parameter int RootStepsPerStage = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bst_pkg::AddrW-1:0]  paddr,
  input  logic [bst_pkg::ApbW-1:0]   pwdata,
  output logic [bst_pkg::ApbW-1:0]   prdata,
  output logic                       pready,
  bst_matrix_if.sink                 matrix,
  bst_sphere_if.source               sphere
);
  import bst_pkg::*;

  localparam int Depth = 6 + RootSteps / RootStepsPerStage;
  localparam int CntW  = $clog2(Depth + 1);

  q_t   offset_x;
  q_t   offset_y;
  q_t   offset_z;
  rad_t local_radius;
  logic wr_en;

  matrix_t mtx;
  vec_t    offset;
  logic    f_valid;
  logic    f_ready;
  front_t  f_data;
  logic    r_valid;
  logic    r_ready;
  root_t   r_data;
  sphere_t s_data;

  logic            acc_in;
  logic            acc_out;
  logic [CntW-1:0] inflight;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
      local_radius <= RadiusReset;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegOffX: offset_x     <= pwdata[DataW-1:0];
        RegOffY: offset_y     <= pwdata[DataW-1:0];
        RegOffZ: offset_z     <= pwdata[DataW-1:0];
        RegRad:  local_radius <= pwdata[RadW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegOffX: prdata = offset_x;
      RegOffY: prdata = offset_y;
      RegOffZ: prdata = offset_z;
      RegRad:  prdata = {1'b0, local_radius};
      default: prdata = '0;
    endcase
  end

  assign mtx.col0  = '{x: matrix.col0_x, y: matrix.col0_y, z: matrix.col0_z};
  assign mtx.col1  = '{x: matrix.col1_x, y: matrix.col1_y, z: matrix.col1_z};
  assign mtx.col2  = '{x: matrix.col2_x, y: matrix.col2_y, z: matrix.col2_z};
  assign mtx.trans = '{x: matrix.trans_x, y: matrix.trans_y, z: matrix.trans_z};
  assign offset    = '{x: offset_x, y: offset_y, z: offset_z};

  bst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (matrix.valid),
    .in_ready  (matrix.ready),
    .in_data   (mtx),
    .offset    (offset),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  bst_sqrt #(
    .StepsPerStage (RootStepsPerStage)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  bst_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .in_data   (r_data),
    .radius    (local_radius),
    .out_valid (sphere.valid),
    .out_ready (sphere.ready),
    .out_data  (s_data)
  );

  assign sphere.center_x     = s_data.center.x;
  assign sphere.center_y     = s_data.center.y;
  assign sphere.center_z     = s_data.center.z;
  assign sphere.world_radius = s_data.radius;

  // items in flight, for checking only
  assign acc_in  = matrix.valid & matrix.ready;
  assign acc_out = sphere.valid & sphere.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (acc_in && !acc_out) begin
      inflight <= inflight + 1'b1;
    end else if (acc_out && !acc_in) begin
      inflight <= inflight - 1'b1;
    end
  end

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= CntW'(Depth))
    else $error("more beats in flight than pipeline stages");

  a_empty_no_output: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !sphere.valid)
    else $error("output beat with empty pipeline");

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    sphere.ready |-> matrix.ready)
    else $error("input stalled while output drains");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (inflight == CntW'(Depth)) && !sphere.ready |-> !matrix.ready)
    else $error("input taken with full pipeline");

endmodule
